// File: rtl/core/slaf_pkg.sv
`default_nettype none

package slaf_pkg;

	// Fixed field widths of the request and response items and the config port
	localparam int unsigned FREE_RANGE_W = 3;
	localparam int unsigned FREE_SLOT_W  = 8;
	localparam int unsigned CFG_INDEX_W  = 2;
	localparam int unsigned CFG_DATA_W   = 4;

	// Request opcodes
	localparam logic CMD_ALLOC = 1'b0;
	localparam logic CMD_FREE  = 1'b1;

	// Configuration register indexes
	localparam logic [CFG_INDEX_W-1:0] CFG_SLOT_LOG2  = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_MAX_RANGES = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] CFG_ROBUST     = 2'd2;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_OOM   = 2'd1,
		ST_LIVE  = 2'd2,
		ST_DFREE = 2'd3
	} slaf_status_t;

	typedef struct packed {
		logic                    cmd;
		logic [FREE_RANGE_W-1:0] free_range;
		logic [FREE_SLOT_W-1:0]  free_slot;
	} slaf_req_t;

	typedef struct packed {
		slaf_status_t            status;
		logic [FREE_RANGE_W-1:0] range_index;
		logic [FREE_SLOT_W-1:0]  slot_index;
	} slaf_rsp_t;

	// Controller to datapath
	typedef struct packed {
		logic load;      // capture the request
		logic look;      // pick target slot, issue bitmap read
		logic commit;    // check, write back, load response
		logic clr_step;  // bitmap clearing pass, one entry
	} slaf_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic clr_last;
	} slaf_stat_t;

endpackage

`default_nettype wire

// File: rtl/core/slaf_stream_if.sv
`default_nettype none

interface slaf_stream_if #(
	parameter type T = logic
) ();
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// File: rtl/core/slaf_ram.sv
`default_nettype none

module slaf_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

// File: rtl/core/slaf_ctrl.sv
`default_nettype none

module slaf_ctrl import slaf_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       req_valid,
	output logic            req_ready,
	output logic            rsp_valid,
	input  wire logic       rsp_ready,
	output slaf_cmd_t       cmd,
	input  wire slaf_stat_t stat
);

	typedef enum logic [1:0] {
		S_CLEAR,
		S_IDLE,
		S_LOOK,
		S_CHECK
	} state_t;

	state_t state_q;
	logic   rsp_valid_q;
	logic   commit;

	assign commit    = (state_q == S_CHECK) && (!rsp_valid_q || rsp_ready);
	assign req_ready = (state_q == S_IDLE);
	assign rsp_valid = rsp_valid_q;

	always_comb begin
		cmd          = '0;
		cmd.load     = (state_q == S_IDLE) && req_valid;
		cmd.look     = (state_q == S_LOOK);
		cmd.commit   = commit;
		cmd.clr_step = (state_q == S_CLEAR);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			rsp_valid_q <= 1'b0;
		end else begin
			case (state_q)
				S_CLEAR: begin
					if (stat.clr_last) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (req_valid) begin
						state_q <= S_LOOK;
					end
				end
				S_LOOK: begin
					state_q <= S_CHECK;
				end
				S_CHECK: begin
					if (commit) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase

			if (commit) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	a_rsp_held: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && !rsp_ready |=> rsp_valid_q)
		else $error("response dropped while stalled");

	a_seq: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> (state_q == S_LOOK) ##1 (state_q == S_CHECK))
		else $error("request did not walk look/check");

endmodule

`default_nettype wire

// File: rtl/core/slaf_dpath.sv
`default_nettype none

module slaf_dpath import slaf_pkg::*; #(
	parameter int unsigned MAX_RANGES      = 8,
	parameter int unsigned SLOTS_PER_RANGE = 256
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   cfg_we,
	input  wire logic [CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [CFG_DATA_W-1:0]  cfg_data,
	input  wire slaf_req_t              req_data,
	output slaf_rsp_t                   rsp_data,
	input  wire slaf_cmd_t              cmd,
	output slaf_stat_t                  stat
);

	localparam int unsigned RW     = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;
	localparam int unsigned SW     = $clog2(SLOTS_PER_RANGE);
	localparam int unsigned TOTAL  = MAX_RANGES * SLOTS_PER_RANGE;
	localparam int unsigned AW     = $clog2(TOTAL);
	localparam int unsigned FCW    = $clog2(TOTAL + 1);
	localparam int unsigned NW     = $clog2(SLOTS_PER_RANGE + 1);
	localparam int unsigned RUW    = $clog2(MAX_RANGES + 1);
	localparam int unsigned MW     = RW + SW;
	localparam int unsigned MDEPTH = 1 << MW;
	localparam int unsigned RCW    = (RUW > FREE_RANGE_W) ? RUW : FREE_RANGE_W;
	localparam int unsigned SCW    = (NW > FREE_SLOT_W) ? NW : FREE_SLOT_W;
	localparam int unsigned LCW    = (RUW > CFG_DATA_W) ? RUW : CFG_DATA_W;

	typedef enum logic [1:0] {
		K_FREE,
		K_POP,
		K_FRESH
	} kind_t;

	// configuration
	logic [CFG_DATA_W-1:0] lg_q;
	logic [CFG_DATA_W-1:0] mr_q;
	logic                  rob_q;

	// allocator state
	logic [FCW-1:0] free_count_q;
	logic [NW-1:0]  next_unused_q;
	logic [RUW-1:0] ranges_used_q;
	logic [MW-1:0]  clr_cnt_q;

	// captured request
	logic                    cmd_q;
	logic [FREE_RANGE_W-1:0] fr_q;
	logic [FREE_SLOT_W-1:0]  fs_q;

	// decided in look, used in check
	kind_t         kind_q;
	logic          bad_q;
	logic          open_new_q;
	logic [RW-1:0] tgt_r_q;
	logic [SW-1:0] tgt_s_q;

	slaf_rsp_t rsp_q;

	// look stage logic
	logic [CFG_DATA_W-1:0] lg_eff;
	logic [16:0]           pow;
	logic [NW-1:0]         slots;
	logic [RUW-1:0]        lim;
	logic [RUW-1:0]        ru_m1;
	logic                  free_bad;
	logic                  range_full;
	logic                  oom;
	kind_t                 kind_c;
	logic                  bad_c;
	logic                  open_c;
	logic [RW-1:0]         tgt_r_c;
	logic [SW-1:0]         tgt_s_c;

	// memories
	logic [MW-1:0] stk_rdata;
	logic          stk_we;
	logic [AW-1:0] stk_raddr;
	logic [0:0]    map_rdata;
	logic          map_we;
	logic [MW-1:0] map_waddr;
	logic [0:0]    map_wdata;
	logic [MW-1:0] map_raddr;

	// check stage logic
	logic         do_free;
	logic         do_alloc;
	slaf_status_t st_c;

	always_comb begin
		lg_eff = (lg_q == '0) ? CFG_DATA_W'(1) : lg_q;
		pow    = 17'(1) << lg_eff;
		slots  = (pow > 17'(SLOTS_PER_RANGE)) ? NW'(SLOTS_PER_RANGE) : NW'(pow);
		if ((mr_q == '0) || (LCW'(mr_q) > LCW'(MAX_RANGES))) begin
			lim = RUW'(MAX_RANGES);
		end else begin
			lim = RUW'(mr_q);
		end
		ru_m1 = ranges_used_q - RUW'(1);

		free_bad   = (RCW'(fr_q) >= RCW'(ranges_used_q))
		          || (SCW'(fs_q) >= SCW'(slots))
		          || (free_count_q == FCW'(TOTAL));
		range_full = (next_unused_q >= slots);
		oom        = range_full && ((ranges_used_q >= lim)
		          || (ranges_used_q >= RUW'(MAX_RANGES)));

		open_c = 1'b0;
		if (cmd_q == CMD_FREE) begin
			kind_c  = K_FREE;
			bad_c   = free_bad;
			tgt_r_c = RW'(fr_q);
			tgt_s_c = SW'(fs_q);
		end else if (free_count_q != '0) begin
			kind_c  = K_POP;
			bad_c   = 1'b0;
			tgt_r_c = stk_rdata[SW +: RW];
			tgt_s_c = stk_rdata[SW-1:0];
		end else begin
			kind_c = K_FRESH;
			bad_c  = oom;
			if (range_full) begin
				open_c  = 1'b1;
				tgt_r_c = RW'(ranges_used_q);
				tgt_s_c = '0;
			end else begin
				tgt_r_c = RW'(ru_m1);
				tgt_s_c = SW'(next_unused_q);
			end
		end
	end

	// top of stack is read while idle; ready by the look cycle
	assign stk_raddr = AW'(free_count_q - FCW'(1));
	assign stk_we    = cmd.commit && do_free;

	// bitmap read address holds through a stalled check
	assign map_raddr = cmd.look ? {tgt_r_c, tgt_s_c} : {tgt_r_q, tgt_s_q};
	assign map_we    = cmd.clr_step || (cmd.commit && (do_free || do_alloc));
	assign map_waddr = cmd.clr_step ? clr_cnt_q : {tgt_r_q, tgt_s_q};
	assign map_wdata = cmd.clr_step ? 1'b0 : do_alloc;

	slaf_ram #(
		.WIDTH (MW),
		.DEPTH (TOTAL)
	) u_stack (
		.clk   (clk),
		.we    (stk_we),
		.waddr (AW'(free_count_q)),
		.wdata ({tgt_r_q, tgt_s_q}),
		.raddr (stk_raddr),
		.rdata (stk_rdata)
	);

	slaf_ram #(
		.WIDTH (1),
		.DEPTH (MDEPTH)
	) u_map (
		.clk   (clk),
		.we    (map_we),
		.waddr (map_waddr),
		.wdata (map_wdata),
		.raddr (map_raddr),
		.rdata (map_rdata)
	);

	always_comb begin
		do_free  = 1'b0;
		do_alloc = 1'b0;
		st_c     = ST_OK;
		case (kind_q)
			K_FREE: begin
				if (bad_q || (rob_q && !map_rdata[0])) begin
					st_c = ST_DFREE;
				end else begin
					do_free = 1'b1;
				end
			end
			K_POP: begin
				if (rob_q && map_rdata[0]) begin
					st_c = ST_LIVE;
				end else begin
					do_alloc = 1'b1;
				end
			end
			K_FRESH: begin
				if (bad_q) begin
					st_c = ST_OOM;
				end else if (rob_q && map_rdata[0]) begin
					st_c = ST_LIVE;
				end else begin
					do_alloc = 1'b1;
				end
			end
			default: begin
				st_c = ST_DFREE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lg_q          <= CFG_DATA_W'(8);
			mr_q          <= '0;
			rob_q         <= 1'b0;
			free_count_q  <= '0;
			next_unused_q <= '0;
			ranges_used_q <= RUW'(1);
			clr_cnt_q     <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_SLOT_LOG2:  lg_q  <= cfg_data;
					CFG_MAX_RANGES: mr_q  <= cfg_data;
					CFG_ROBUST:     rob_q <= cfg_data[0];
					default: begin
					end
				endcase
			end
			if (cmd.clr_step) begin
				clr_cnt_q <= clr_cnt_q + MW'(1);
			end
			if (cmd.commit && do_free) begin
				free_count_q <= free_count_q + FCW'(1);
			end
			if (cmd.commit && do_alloc) begin
				if (kind_q == K_POP) begin
					free_count_q <= free_count_q - FCW'(1);
				end else begin
					next_unused_q <= NW'(tgt_s_q) + NW'(1);
					if (open_new_q) begin
						ranges_used_q <= ranges_used_q + RUW'(1);
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cmd_q <= req_data.cmd;
			fr_q  <= req_data.free_range;
			fs_q  <= req_data.free_slot;
		end
		if (cmd.look) begin
			kind_q     <= kind_c;
			bad_q      <= bad_c;
			open_new_q <= open_c;
			tgt_r_q    <= tgt_r_c;
			tgt_s_q    <= tgt_s_c;
		end
		if (cmd.commit) begin
			rsp_q.status      <= st_c;
			rsp_q.range_index <= do_alloc ? FREE_RANGE_W'(tgt_r_q) : '0;
			rsp_q.slot_index  <= do_alloc ? FREE_SLOT_W'(tgt_s_q) : '0;
		end
	end

	assign rsp_data      = rsp_q;
	assign stat.clr_last = &clr_cnt_q;

	a_fc_bound: assert property (@(posedge clk) disable iff (!arst_n)
		free_count_q <= FCW'(TOTAL))
		else $error("free count beyond stack depth");

	a_ru_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(ranges_used_q != '0) && (ranges_used_q <= RUW'(MAX_RANGES)))
		else $error("ranges used out of bounds");

	a_nu_bound: assert property (@(posedge clk) disable iff (!arst_n)
		next_unused_q <= NW'(SLOTS_PER_RANGE))
		else $error("next unused slot past range end");

endmodule

`default_nettype wire

// File: rtl/core/slot_allocator_free_list_unit.sv
// Fixed-size slot allocator with a LIFO free list.
// req channel: one request per item, cmd selects allocate or free; on free,
//   free_range/free_slot name the slot being returned.
// rsp channel: exactly one response per request: status (ok, out of memory,
//   slot already live, double free) and, for a good allocate, the slot.
// cfg port: cfg_we/cfg_index/cfg_data write slot_count_log2 (0),
//   max_ranges (1), robust (2); only while no request is in flight.
// Sequence: a request taken in idle has its response registered when its
//   check cycle commits (rsp.valid high from then); no new request is taken
//   before idle. The free stack top is read while idle, the bitmap is read
//   in the look cycle, and the check cycle writes stack, bitmap and counters
//   back; both RAMs have a registered read port, so these three steps chain.
// Reset: counters clear, one range exists, and the allocation bitmap is
//   cleared one entry a cycle, a pass over 2^(RW+SW) entries (2048 with
//   defaults); req.ready stays low during the pass, config writes still land.
// Stall: the response sits in an output register; a new request is still
//   taken, and its check cycle waits until the held response is taken.
`default_nettype none

module slot_allocator_free_list_unit import slaf_pkg::*; #(
	parameter int unsigned MAX_RANGES      = 8,
	parameter int unsigned SLOTS_PER_RANGE = 256
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   cfg_we,
	input  wire logic [CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [CFG_DATA_W-1:0]  cfg_data,
	slaf_stream_if.sink                 req,
	slaf_stream_if.source               rsp
);

	slaf_cmd_t  cmd;
	slaf_stat_t stat;

	// sequencing: clear pass, idle, look, check
	slaf_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.cmd       (cmd),
		.stat      (stat)
	);

	// counters, config, free stack and bitmap RAMs, response register
	slaf_dpath #(
		.MAX_RANGES      (MAX_RANGES),
		.SLOTS_PER_RANGE (SLOTS_PER_RANGE)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.req_data  (req.data),
		.rsp_data  (rsp.data),
		.cmd       (cmd),
		.stat      (stat)
	);

endmodule

`default_nettype wire

// File: tb/testbench.sv
`timescale 1ns / 100ps

// Slot allocator free-list testbench.
// Requests come from a queue that the stimulus thread fills; a negedge driver
// offers them with random gaps. A posedge monitor runs every accepted request
// through a local allocator model and checks each response, field by field,
// against the oldest predicted response.
module testbench;
	import slaf_pkg::*;

	localparam int unsigned MAX_RANGES      = 8;
	localparam int unsigned SLOTS_PER_RANGE = 256;
	localparam int unsigned TOTAL_SLOTS     = MAX_RANGES * SLOTS_PER_RANGE;
	// The budget covers the clearing pass after reset and is several times the
	// slowest item stream with both sides stalling.
	localparam int unsigned CYCLE_LIMIT     = 400_000;
	localparam int unsigned DRAIN_CYCLES    = 20;
	localparam int unsigned IDLE_PCT        = 35;
	localparam int unsigned HOLD_AT_RSP     = 480;
	localparam int unsigned HOLD_CYCLES     = 250;

	logic                   clk;
	logic                   arst_n;
	logic                   cfg_we;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_data;

	slaf_stream_if #(.T(slaf_req_t)) req_if ();
	slaf_stream_if #(.T(slaf_rsp_t)) rsp_if ();

	slot_allocator_free_list_unit #(
		.MAX_RANGES      (MAX_RANGES),
		.SLOTS_PER_RANGE (SLOTS_PER_RANGE)
	) u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.req       (req_if),
		.rsp       (rsp_if)
	);

	// ---------------------------------------------------------------------
	// Allocator model state, reset values of the block
	// ---------------------------------------------------------------------
	logic [3:0]  cfg_log2   = 4'd8;
	logic [3:0]  cfg_max    = 4'd0;
	logic        robust_on  = 1'b0;

	logic [10:0] freed_slots [TOTAL_SLOTS];   // LIFO of returned slots
	logic [11:0] stack_depth = '0;
	logic [8:0]  fresh_slot  = '0;            // next unused slot of newest range
	logic [3:0]  open_ranges = 4'd1;          // range 0 exists from reset
	bit          live_map    [TOTAL_SLOTS];   // allocation bitmap, all clear

	// ---------------------------------------------------------------------
	// Testbench bookkeeping
	// ---------------------------------------------------------------------
	slaf_req_t   pending_q [$];               // requests waiting for the driver
	slaf_rsp_t   expected_rsp_q [$];          // predicted responses, oldest first
	int unsigned issued_cnt = 0;              // requests queued so far
	int unsigned done_cnt   = 0;              // responses matched so far
	int unsigned err_count  = 0;
	int unsigned cycle_cnt  = 0;
	bit          req_fire   = 1'b0;           // request taken at last rising edge
	bit          no_idle    = 1'b0;           // both sides stream without gaps
	int unsigned hold_left  = 0;
	bit          hold_done  = 1'b0;

	// Slots per range: a log2 of 0 behaves as 1, and the count never exceeds
	// the physical range size.
	function automatic int unsigned slots_per_range();
		int unsigned lg;
		lg = (cfg_log2 == 0) ? 1 : 32'(cfg_log2);
		return ((1 << lg) > SLOTS_PER_RANGE) ? SLOTS_PER_RANGE : (1 << lg);
	endfunction

	// Range limit: 0 or anything past the built-in maximum means the maximum.
	function automatic int unsigned range_cap();
		return (cfg_max == 0 || cfg_max > MAX_RANGES) ? MAX_RANGES : 32'(cfg_max);
	endfunction

	// Applies one request to the model and returns the response it produces.
	function automatic slaf_rsp_t allocator_step(slaf_req_t rq);
		slaf_rsp_t   rs;
		int unsigned slots;
		int unsigned idx;
		int unsigned rng;
		int unsigned slt;
		bit          fresh_range;
		rs.status      = ST_OK;
		rs.range_index = '0;
		rs.slot_index  = '0;
		slots          = slots_per_range();
		if (rq.cmd == CMD_FREE) begin
			// Nonexistent slot or a full stack is reported as a double free.
			if (rq.free_range >= open_ranges || rq.free_slot >= slots ||
			    stack_depth >= TOTAL_SLOTS) begin
				rs.status = ST_DFREE;
			end else begin
				idx = rq.free_range * SLOTS_PER_RANGE + rq.free_slot;
				if (robust_on && !live_map[idx]) begin
					rs.status = ST_DFREE;
				end else begin
					live_map[idx]            = 1'b0;
					freed_slots[stack_depth] = 11'(idx);
					stack_depth++;
				end
			end
		end else if (stack_depth != 0) begin
			// Most recently freed slot goes out first.
			idx = 32'(freed_slots[stack_depth - 1]);
			if (robust_on && live_map[idx]) begin
				rs.status = ST_LIVE;
			end else begin
				live_map[idx]  = 1'b1;
				stack_depth--;
				rs.range_index = 3'(idx / SLOTS_PER_RANGE);
				rs.slot_index  = 8'(idx % SLOTS_PER_RANGE);
			end
		end else begin
			// Stack empty: carve from the newest range, opening another when
			// it is full (which includes a slot count lowered under it).
			rng         = 32'(open_ranges) - 1;
			slt         = 32'(fresh_slot);
			fresh_range = 1'b0;
			if (slt >= slots) begin
				if (open_ranges >= range_cap()) begin
					rs.status = ST_OOM;
				end else begin
					fresh_range = 1'b1;
					rng         = 32'(open_ranges);
					slt         = 0;
				end
			end
			if (rs.status == ST_OK) begin
				idx = rng * SLOTS_PER_RANGE + slt;
				if (robust_on && live_map[idx]) begin
					rs.status = ST_LIVE;
				end else begin
					if (fresh_range)
						open_ranges++;
					fresh_slot     = 9'(slt + 1);
					live_map[idx]  = 1'b1;
					rs.range_index = 3'(rng);
					rs.slot_index  = 8'(slt);
				end
			end
		end
		return rs;
	endfunction

	// Random request. Frees mostly return a slot the model holds live; the
	// rest is noise that can land outside the current geometry.
	function automatic slaf_req_t random_request(int unsigned alloc_pct);
		slaf_req_t   rq;
		int unsigned roll;
		int unsigned slots;
		rq.cmd        = CMD_FREE;
		rq.free_range = 3'($urandom_range(7));
		rq.free_slot  = 8'($urandom_range(255));
		roll          = $urandom_range(99);
		slots         = slots_per_range();
		if (roll < alloc_pct) begin
			rq.cmd = CMD_ALLOC;
		end else if (roll < 94) begin
			for (int tries = 0; tries < 48; tries++) begin
				rq.free_range = 3'($urandom_range(32'(open_ranges) - 1));
				rq.free_slot  = 8'($urandom_range(slots - 1));
				if (live_map[rq.free_range * SLOTS_PER_RANGE + rq.free_slot])
					break;
			end
		end
		return rq;
	endfunction

	// ---------------------------------------------------------------------
	// Clock and watchdog
	// ---------------------------------------------------------------------
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt >= CYCLE_LIMIT) begin
			$display("testbench: FAIL");
			$finish;
		end
	end

	// ---------------------------------------------------------------------
	// Request driver: holds a request until taken, random gaps between them
	// ---------------------------------------------------------------------
	always @(negedge clk) begin
		if (!arst_n) begin
			req_if.valid <= 1'b0;
			req_if.data  <= '0;
		end else if (!req_if.valid || req_fire) begin
			if (pending_q.size() != 0 && (no_idle || $urandom_range(99) >= IDLE_PCT)) begin
				req_if.data  <= pending_q.pop_front();
				req_if.valid <= 1'b1;
			end else begin
				req_if.valid <= 1'b0;
			end
		end
	end

	// Response side ready: random stalls, plus one long hold-off so the
	// block backs up and drops req.ready while requests keep coming.
	always @(negedge clk) begin
		if (!arst_n) begin
			rsp_if.ready <= 1'b0;
		end else if (hold_left != 0) begin
			rsp_if.ready <= 1'b0;
			hold_left    <= hold_left - 1;
		end else if (!hold_done && done_cnt >= HOLD_AT_RSP) begin
			rsp_if.ready <= 1'b0;
			hold_left    <= HOLD_CYCLES;
			hold_done    <= 1'b1;
		end else begin
			rsp_if.ready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
		end
	end

	// ---------------------------------------------------------------------
	// Monitor: predict on request accept, check on response accept
	// ---------------------------------------------------------------------
	always @(posedge clk) begin
		slaf_rsp_t want;
		req_fire = arst_n && req_if.valid && req_if.ready;
		if (req_fire)
			expected_rsp_q.push_back(allocator_step(req_if.data));
		if (arst_n && rsp_if.valid && rsp_if.ready) begin
			if (expected_rsp_q.size() == 0) begin
				$error("unexpected response: status %0d range %0d slot %0d",
				       rsp_if.data.status, rsp_if.data.range_index, rsp_if.data.slot_index);
				err_count++;
			end else begin
				want = expected_rsp_q.pop_front();
				if (rsp_if.data.status !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, rsp_if.data.status);
					err_count++;
				end
				if (rsp_if.data.range_index !== want.range_index) begin
					$error("range_index: expected %0d, got %0d",
					       want.range_index, rsp_if.data.range_index);
					err_count++;
				end
				if (rsp_if.data.slot_index !== want.slot_index) begin
					$error("slot_index: expected %0d, got %0d",
					       want.slot_index, rsp_if.data.slot_index);
					err_count++;
				end
				done_cnt++;
			end
		end
	end

	// ---------------------------------------------------------------------
	// Stimulus
	// ---------------------------------------------------------------------
	// Queue one request; keeps the queue short so random picks see a model
	// state that is only a few requests behind.
	task automatic send_req(input logic c, input logic [2:0] r, input logic [7:0] s);
		slaf_req_t rq;
		while (pending_q.size() >= 2)
			@(negedge clk);
		rq.cmd        = c;
		rq.free_range = r;
		rq.free_slot  = s;
		pending_q.push_back(rq);
		issued_cnt++;
	endtask

	// Sender pause: wait until every queued request has its response.
	task automatic settle();
		while (done_cnt != issued_cnt)
			@(negedge clk);
	endtask

	// Register write, only with nothing in flight; one cycle of cfg_we.
	task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
	                         input logic [CFG_DATA_W-1:0] val);
		settle();
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		case (idx)
			CFG_SLOT_LOG2:  cfg_log2  = val;
			CFG_MAX_RANGES: cfg_max   = val;
			CFG_ROBUST:     robust_on = val[0];
			default: ;
		endcase
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	task automatic run_phase(input logic [3:0] lg, input logic [3:0] mr, input logic rb,
	                         input int unsigned n, input int unsigned alloc_pct);
		slaf_req_t rq;
		write_reg(CFG_SLOT_LOG2, lg);
		write_reg(CFG_MAX_RANGES, mr);
		write_reg(CFG_ROBUST, {3'b000, rb});
		repeat (n) begin
			rq = random_request(alloc_pct);
			send_req(rq.cmd, rq.free_range, rq.free_slot);
		end
	endtask

	initial begin
		arst_n       = 1'b0;
		cfg_we       = 1'b0;
		cfg_index    = '0;
		cfg_data     = '0;
		req_if.valid = 1'b0;
		req_if.data  = '0;
		rsp_if.ready = 1'b0;
		repeat (6) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed: two slots per range (log2 of 0), two ranges, robust.
		write_reg(CFG_SLOT_LOG2, 4'd0);
		write_reg(CFG_MAX_RANGES, 4'd2);
		write_reg(CFG_ROBUST, 4'd1);
		send_req(CMD_ALLOC, 3'd7, 8'd255);   // free fields ignored on alloc
		send_req(CMD_ALLOC, 3'd0, 8'd0);
		send_req(CMD_ALLOC, 3'd0, 8'd0);     // range 0 full, opens range 1
		send_req(CMD_ALLOC, 3'd0, 8'd0);
		send_req(CMD_ALLOC, 3'd0, 8'd0);     // range limit reached: out of memory
		send_req(CMD_FREE, 3'd7, 8'd255);    // nonexistent slot
		send_req(CMD_FREE, 3'd0, 8'd2);      // slot past the slot count
		send_req(CMD_FREE, 3'd2, 8'd0);      // range not opened yet
		send_req(CMD_FREE, 3'd1, 8'd1);
		send_req(CMD_FREE, 3'd1, 8'd1);      // double free
		send_req(CMD_ALLOC, 3'd0, 8'd0);     // pops it back
		send_req(CMD_FREE, 3'd0, 8'd0);
		send_req(CMD_FREE, 3'd0, 8'd1);
		send_req(CMD_ALLOC, 3'd0, 8'd0);     // LIFO order
		send_req(CMD_ALLOC, 3'd0, 8'd0);
		send_req(CMD_ALLOC, 3'd0, 8'd0);

		// Stack top left live: two frees of one slot without checks, one pop.
		write_reg(CFG_ROBUST, 4'd0);
		send_req(CMD_FREE, 3'd0, 8'd0);
		send_req(CMD_FREE, 3'd0, 8'd0);
		send_req(CMD_ALLOC, 3'd0, 8'd0);
		write_reg(CFG_ROBUST, 4'd1);
		send_req(CMD_ALLOC, 3'd0, 8'd0);     // popped slot already live
		write_reg(CFG_ROBUST, 4'd0);
		send_req(CMD_ALLOC, 3'd0, 8'd0);     // no check: handed out again

		// Fresh slot already live: free an unused slot of the newest range
		// and take it back, so the carve pointer hits a live entry.
		write_reg(CFG_SLOT_LOG2, 4'd2);
		send_req(CMD_FREE, 3'd1, 8'd2);
		send_req(CMD_ALLOC, 3'd0, 8'd0);
		write_reg(CFG_ROBUST, 4'd1);
		send_req(CMD_ALLOC, 3'd0, 8'd0);
		write_reg(CFG_ROBUST, 4'd0);
		send_req(CMD_ALLOC, 3'd0, 8'd0);

		// Random phases. Slot count lowered under the newest range, limit
		// lowered below the open ranges, log2 past the cap, limit past max.
		run_phase(4'd1, 4'd3, 1'b1, 120, 60);
		run_phase(4'd3, 4'd4, 1'b1, 200, 55);
		run_phase(4'd15, 4'd0, 1'b1, 200, 55);   // long response hold-off lands here
		settle();
		no_idle = 1'b1;
		run_phase(4'd2, 4'd1, 1'b1, 150, 50);
		settle();
		no_idle = 1'b0;
		run_phase(4'd8, 4'd9, 1'b0, 200, 50);
		run_phase(4'd5, 4'd15, 1'b1, 150, 50);
		run_phase(4'd4, 4'd8, 1'b0, 180, 45);

		settle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (err_count == 0)
			$display("testbench: PASS");
		else
			$display("testbench: FAIL");
		$finish;
	end

endmodule

// File: files.f
rtl/core/slaf_pkg.sv
rtl/core/slaf_stream_if.sv
rtl/core/slaf_ram.sv
rtl/core/slaf_ctrl.sv
rtl/core/slaf_dpath.sv
rtl/core/slot_allocator_free_list_unit.sv
tb/testbench.sv
